/* src/tpu_pkg.sv */
// shared types, constants and decode functions of the tracker pattern unpacker
`default_nettype none

package tpu_pkg;

  // channel memory geometry
  localparam int CHANNELS = 64;
  localparam int SLOT_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // field widths
  localparam int ROWCNT_W = 9;
  localparam int ROWCNT_RESET = 64;
  localparam int CHAN_W   = 6;

  // request codes
  typedef enum logic {
    REQ_DATA  = 1'b0,
    REQ_START = 1'b1
  } req_e;

  // result codes
  typedef enum logic {
    RES_CELL = 1'b0,
    RES_END  = 1'b1
  } res_e;

  // volume column command kinds
  typedef enum logic [3:0] {
    VK_V = 4'd0,
    VK_A = 4'd1,
    VK_B = 4'd2,
    VK_C = 4'd3,
    VK_D = 4'd4,
    VK_E = 4'd5,
    VK_F = 4'd6,
    VK_P = 4'd7,
    VK_G = 4'd8
  } vol_kind_e;

  // volume range starts and ends
  localparam logic [7:0] VOL_ABSENT = 8'd64;
  localparam logic [7:0] VOL_A_LO   = 8'd65;
  localparam logic [7:0] VOL_B_LO   = 8'd75;
  localparam logic [7:0] VOL_C_LO   = 8'd85;
  localparam logic [7:0] VOL_D_LO   = 8'd95;
  localparam logic [7:0] VOL_E_LO   = 8'd105;
  localparam logic [7:0] VOL_F_LO   = 8'd115;
  localparam logic [7:0] VOL_F_HI   = 8'd125;
  localparam logic [7:0] VOL_P_LO   = 8'd128;
  localparam logic [7:0] VOL_G_LO   = 8'd193;
  localparam logic [7:0] VOL_G_HI   = 8'd203;

  // saved channel entry, one memory word
  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] note;
    logic [7:0] inst;
    logic [7:0] vol;
    logic [7:0] cmd;
    logic [7:0] opnd;
  } ent_t;

  typedef struct packed {
    vol_kind_e  kind;
    logic [7:0] value;
  } vol_t;

  // one result item
  typedef struct packed {
    res_e              result_kind;
    logic [7:0]        row_index;
    logic [CHAN_W-1:0] channel_index;
    logic [3:0]        change_flags;
    logic [7:0]        note_value;
    logic [7:0]        instrument_value;
    vol_kind_e         volume_kind;
    logic [7:0]        volume_value;
    logic [7:0]        command_code;
    logic [7:0]        command_operand;
    logic [CHAN_W-1:0] highest_channel;
  } out_t;

  // volume column byte to kind and operand
  function automatic vol_t vol_decode(logic [7:0] v);
    vol_t r;
    r.kind  = VK_V;
    r.value = v;
    priority if (v >= VOL_A_LO && v < VOL_B_LO) begin
      r.kind = VK_A; r.value = v - VOL_A_LO;
    end else if (v >= VOL_B_LO && v < VOL_C_LO) begin
      r.kind = VK_B; r.value = v - VOL_B_LO;
    end else if (v >= VOL_C_LO && v < VOL_D_LO) begin
      r.kind = VK_C; r.value = v - VOL_C_LO;
    end else if (v >= VOL_D_LO && v < VOL_E_LO) begin
      r.kind = VK_D; r.value = v - VOL_D_LO;
    end else if (v >= VOL_E_LO && v < VOL_F_LO) begin
      r.kind = VK_E; r.value = v - VOL_E_LO;
    end else if (v >= VOL_F_LO && v < VOL_F_HI) begin
      r.kind = VK_F; r.value = v - VOL_F_LO;
    end else if (v >= VOL_P_LO && v < VOL_G_LO) begin
      r.kind = VK_P; r.value = v - VOL_P_LO;
    end else if (v >= VOL_G_LO && v < VOL_G_HI) begin
      r.kind = VK_G; r.value = v - VOL_G_LO;
    end else begin
      r.kind = VK_V; r.value = v;
    end
    return r;
  endfunction

  // cell entry from a finished channel entry
  function automatic out_t make_cell(ent_t e, logic [ROWCNT_W-1:0] row,
                                     logic [CHAN_W-1:0] ch, logic [CHAN_W-1:0] hi);
    out_t r;
    vol_t vd;
    r = '0;
    r.result_kind   = RES_CELL;
    r.row_index     = row[7:0];
    r.channel_index = ch;
    r.highest_channel = hi;
    if (e.mask[0] || e.mask[4]) begin
      r.change_flags[0] = 1'b1;
      r.note_value      = e.note;
    end
    if (e.mask[1] || e.mask[5]) begin
      r.change_flags[1]  = 1'b1;
      r.instrument_value = e.inst;
    end
    if (e.mask[2] || e.mask[6]) begin
      r.change_flags[2] = 1'b1;
      vd = vol_decode(e.vol);
    end else begin
      vd.kind  = VK_V;
      vd.value = VOL_ABSENT;
    end
    r.volume_kind  = vd.kind;
    r.volume_value = vd.value;
    if (e.mask[3] || e.mask[7]) begin
      r.change_flags[3] = 1'b1;
      r.command_code    = e.cmd;
      r.command_operand = e.opnd;
    end
    return r;
  endfunction

  // pattern end entry
  function automatic out_t make_end(logic [ROWCNT_W-1:0] row, logic [CHAN_W-1:0] hi);
    out_t r;
    r = '0;
    r.result_kind     = RES_END;
    r.row_index       = row[7:0];
    r.volume_kind     = VK_V;
    r.highest_channel = hi;
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/tpu_if.sv */
// handshake channels of the tracker pattern unpacker: byte input, result output, config
`default_nettype none

interface tpu_in_if;
  import tpu_pkg::*;
  logic       valid;
  logic       ready;
  req_e       req_type;
  logic [7:0] data_byte;
  modport source (output valid, req_type, data_byte, input ready);
  modport sink   (input valid, req_type, data_byte, output ready);
endinterface

interface tpu_out_if;
  import tpu_pkg::*;
  logic              valid;
  logic              ready;
  res_e              result_kind;
  logic [7:0]        row_index;
  logic [CHAN_W-1:0] channel_index;
  logic [3:0]        change_flags;
  logic [7:0]        note_value;
  logic [7:0]        instrument_value;
  vol_kind_e         volume_kind;
  logic [7:0]        volume_value;
  logic [7:0]        command_code;
  logic [7:0]        command_operand;
  logic [CHAN_W-1:0] highest_channel;
  modport source (output valid, result_kind, row_index, channel_index, change_flags,
                  note_value, instrument_value, volume_kind, volume_value,
                  command_code, command_operand, highest_channel, input ready);
  modport sink   (input valid, result_kind, row_index, channel_index, change_flags,
                  note_value, instrument_value, volume_kind, volume_value,
                  command_code, command_operand, highest_channel, output ready);
endinterface

interface tpu_cfg_if;
  import tpu_pkg::*;
  logic                valid;
  logic                ready;
  logic [ROWCNT_W-1:0] row_count;
  modport source (output valid, row_count, input ready);
  modport sink   (input valid, row_count, output ready);
endinterface

`default_nettype wire

/* src/tpu_ram.sv */
// generic single write port, single read port ram with registered read data
`default_nettype none

module tpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/tracker_pattern_unpacker.sv */
// tracker pattern unpacker top level: byte parser over a per-channel entry ram
//
//  channel  | dir | payload                                  | accepted when
//  ---------+-----+------------------------------------------+-----------------------
//  req_i    | in  | req_type, data_byte                      | valid & ready
//  rsp_o    | out | cell or pattern end item (11 fields)     | valid & ready
//  cfg_i    | in  | row_count                                | valid & ready (ready=1)
//
// one byte is taken per cycle unless a stall holds it; the ram is written as each
// field byte arrives. a channel byte without a new mask adds a resolve phase, since
// the next phase waits for the saved mask from the entry ram (registered read).
// reset and a start item clear 64 per-channel valid bits at once, so an entry
// never written in this pattern reads as zero; there is no clearing pass.
// results go through a two-entry output queue; input also stalls while it is full.
`default_nettype none

module tracker_pattern_unpacker import tpu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tpu_in_if.sink    req_i,
  tpu_out_if.source rsp_o,
  tpu_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    PH_CHAN,
    PH_RESOLVE,
    PH_MASK,
    PH_NOTE,
    PH_INST,
    PH_VOL,
    PH_CMD,
    PH_CMDVAL,
    PH_DONE
  } phase_e;

  // next byte the mask asks for after position pos (0 mask .. 3 volume)
  function automatic phase_e advance(logic [3:0] m, logic [1:0] pos);
    phase_e nxt;
    priority if (m[0] && pos == 2'd0) begin
      nxt = PH_NOTE;
    end else if (m[1] && pos <= 2'd1) begin
      nxt = PH_INST;
    end else if (m[2] && pos <= 2'd2) begin
      nxt = PH_VOL;
    end else if (m[3]) begin
      nxt = PH_CMD;
    end else begin
      nxt = PH_CHAN;
    end
    return nxt;
  endfunction

  // control state
  phase_e              phase_q, phase_d;
  logic                ld_q, ld_d;
  logic [CHAN_W-1:0]   chan_q, chan_d;
  logic [CHAN_W-1:0]   max_q, max_d;
  logic [ROWCNT_W-1:0] row_q, row_d;
  logic [ROWCNT_W-1:0] rc_q;
  logic [CHANNELS-1:0] vld_q, vld_d;

  // payload state
  ent_t cur_q, cur_d;
  logic vld_rd_q;

  // output queue
  out_t       fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       fifo_full;
  logic       push, pop;
  out_t       push_data;

  // ram signals
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  ent_t              ram_wdata, ram_rdata;

  // working signals
  ent_t                ent, upd;
  logic                in_acc;
  logic [CHAN_W-1:0]   new_chan;
  logic [ROWCNT_W-1:0] limit;
  logic [ROWCNT_W:0]   next_row;
  phase_e              nxt;

  tpu_ram #(
    .WIDTH ($bits(ent_t)),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // config port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= ROWCNT_W'(ROWCNT_RESET);
    end else if (cfg_i.valid) begin
      rc_q <= cfg_i.row_count;
    end
  end

  // handshakes
  assign fifo_full   = (cnt_q == 2'd2);
  assign req_i.ready = !fifo_full && (phase_q != PH_RESOLVE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign pop         = (cnt_q != 2'd0) && rsp_o.ready;

  // entry of the current cell: fresh ram data right after a channel byte
  assign ent = ld_q ? (vld_rd_q ? ram_rdata : '0) : cur_q;

  assign new_chan  = CHAN_W'(req_i.data_byte - 8'd1);
  assign limit     = (rc_q == '0) ? ROWCNT_W'(1) : rc_q;
  assign next_row  = {1'b0, row_q} + (ROWCNT_W+1)'(1);
  assign ram_waddr = chan_q[SLOT_W-1:0];
  assign ram_raddr = new_chan[SLOT_W-1:0];
  assign ram_wdata = upd;

  // byte parser
  always_comb begin
    phase_d   = phase_q;
    ld_d      = 1'b0;
    chan_d    = chan_q;
    max_d     = max_q;
    row_d     = row_q;
    vld_d     = vld_q;
    cur_d     = ent;
    upd       = ent;
    nxt       = PH_CHAN;
    push      = 1'b0;
    push_data = make_end(row_q, max_q);
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    if (phase_q == PH_RESOLVE) begin
      // saved mask is back: pick the first byte it asks for, or finish at once
      if (!fifo_full) begin
        nxt     = advance(ent.mask[3:0], 2'd0);
        phase_d = nxt;
        if (nxt == PH_CHAN) begin
          push      = 1'b1;
          push_data = make_cell(ent, row_q, chan_q, max_q);
        end
      end
    end else if (in_acc) begin
      if (req_i.req_type == REQ_START) begin
        phase_d = PH_CHAN;
        chan_d  = '0;
        max_d   = '0;
        row_d   = '0;
        vld_d   = '0;
      end else begin
        unique case (phase_q)
          PH_CHAN: begin
            if (req_i.data_byte == 8'd0) begin
              // row terminator
              if (next_row >= {1'b0, limit}) begin
                push      = 1'b1;
                push_data = make_end(row_q, max_q);
                phase_d   = PH_DONE;
              end else begin
                row_d = next_row[ROWCNT_W-1:0];
              end
            end else begin
              // channel select, fetch its saved entry
              chan_d  = new_chan;
              max_d   = (new_chan > max_q) ? new_chan : max_q;
              ram_re  = 1'b1;
              ld_d    = 1'b1;
              phase_d = req_i.data_byte[7] ? PH_MASK : PH_RESOLVE;
            end
          end
          PH_MASK, PH_NOTE, PH_INST, PH_VOL: begin
            unique case (phase_q)
              PH_MASK: upd.mask = req_i.data_byte;
              PH_NOTE: upd.note = req_i.data_byte;
              PH_INST: upd.inst = req_i.data_byte;
              default: upd.vol  = req_i.data_byte;
            endcase
            cur_d  = upd;
            ram_we = 1'b1;
            vld_d[chan_q[SLOT_W-1:0]] = 1'b1;
            unique case (phase_q)
              PH_MASK: nxt = advance(upd.mask[3:0], 2'd0);
              PH_NOTE: nxt = advance(upd.mask[3:0], 2'd1);
              PH_INST: nxt = advance(upd.mask[3:0], 2'd2);
              default: nxt = advance(upd.mask[3:0], 2'd3);
            endcase
            phase_d = nxt;
            if (nxt == PH_CHAN) begin
              push      = 1'b1;
              push_data = make_cell(upd, row_q, chan_q, max_q);
            end
          end
          PH_CMD: begin
            upd.cmd = req_i.data_byte;
            cur_d   = upd;
            ram_we  = 1'b1;
            vld_d[chan_q[SLOT_W-1:0]] = 1'b1;
            phase_d = PH_CMDVAL;
          end
          PH_CMDVAL: begin
            upd.opnd  = req_i.data_byte;
            cur_d     = upd;
            ram_we    = 1'b1;
            vld_d[chan_q[SLOT_W-1:0]] = 1'b1;
            push      = 1'b1;
            push_data = make_cell(upd, row_q, chan_q, max_q);
            phase_d   = PH_CHAN;
          end
          default: begin
            // pattern ended: bytes are dropped
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  // parser control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CHAN;
      ld_q    <= 1'b0;
      chan_q  <= '0;
      max_q   <= '0;
      row_q   <= '0;
      vld_q   <= '0;
    end else begin
      phase_q <= phase_d;
      ld_q    <= ld_d;
      chan_q  <= chan_d;
      max_q   <= max_d;
      row_q   <= row_d;
      vld_q   <= vld_d;
    end
  end

  // working entry and valid bit of the fetched slot
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (ram_re) begin
      vld_rd_q <= vld_q[ram_raddr];
    end
  end

  // output queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= push_data;
    end
  end

  // output queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // result channel
  assign rsp_o.valid            = (cnt_q != 2'd0);
  assign rsp_o.result_kind      = fifo_q[rp_q].result_kind;
  assign rsp_o.row_index        = fifo_q[rp_q].row_index;
  assign rsp_o.channel_index    = fifo_q[rp_q].channel_index;
  assign rsp_o.change_flags     = fifo_q[rp_q].change_flags;
  assign rsp_o.note_value       = fifo_q[rp_q].note_value;
  assign rsp_o.instrument_value = fifo_q[rp_q].instrument_value;
  assign rsp_o.volume_kind      = fifo_q[rp_q].volume_kind;
  assign rsp_o.volume_value     = fifo_q[rp_q].volume_value;
  assign rsp_o.command_code     = fifo_q[rp_q].command_code;
  assign rsp_o.command_operand  = fifo_q[rp_q].command_operand;
  assign rsp_o.highest_channel  = fifo_q[rp_q].highest_channel;

endmodule

`default_nettype wire

/* tb/tpu_cell_checker.sv */
// checker for the pattern unpacker: predicts cells and pattern ends from accepted items and compares
`timescale 1ns / 100ps

module tpu_cell_checker import tpu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tpu_in_if         req_mon,
  tpu_out_if        rsp_mon,
  tpu_cfg_if        cfg_mon,
  output int        mism_o,
  output int        pend_o,
  output int        cells_o,
  output int        ends_o
);

  // where the parser stands in the byte stream
  typedef enum logic [2:0] {
    ST_CHAN, ST_MASK, ST_NOTE, ST_INST, ST_VOL, ST_CMD, ST_OPND, ST_DONE
  } parse_e;

  // volume column ranges, entry i decodes to kind i+1
  localparam logic [7:0][7:0] VOL_BASE = {8'd193, 8'd128, 8'd115, 8'd105,
                                          8'd95, 8'd85, 8'd75, 8'd65};
  localparam logic [7:0][7:0] VOL_TOP  = {8'd203, 8'd193, 8'd125, 8'd115,
                                          8'd105, 8'd95, 8'd85, 8'd75};

  // remembered per-channel values
  logic [7:0] mask_mem [CHANNELS];
  logic [7:0] note_mem [CHANNELS];
  logic [7:0] inst_mem [CHANNELS];
  logic [7:0] vol_mem  [CHANNELS];
  logic [7:0] cmd_mem  [CHANNELS];
  logic [7:0] opnd_mem [CHANNELS];

  parse_e            phase;
  logic [CHAN_W-1:0] chan;
  logic [CHAN_W-1:0] top_chan;
  logic [8:0]        row;
  logic [8:0]        rows_limit;

  out_t cells_due [$];
  int   mism;
  int   n_cells;
  int   n_ends;

  // start of a pattern wipes the channel memory
  function automatic void clear_pattern();
    for (int i = 0; i < CHANNELS; i++) begin
      mask_mem[i] = '0;
      note_mem[i] = '0;
      inst_mem[i] = '0;
      vol_mem[i]  = '0;
      cmd_mem[i]  = '0;
      opnd_mem[i] = '0;
    end
    phase    = ST_CHAN;
    chan     = '0;
    top_chan = '0;
    row      = '0;
  endfunction

  // unmatched bytes pass raw as plain volume
  function automatic void split_volume(input logic [7:0] v, output vol_kind_e k,
                                       output logic [7:0] o);
    k = VK_V;
    o = v;
    for (int i = 0; i < 8; i++) begin
      if (v >= VOL_BASE[i] && v < VOL_TOP[i]) begin
        k = vol_kind_e'(i + 1);
        o = v - VOL_BASE[i];
      end
    end
  endfunction

  // cell of the current channel is complete
  function automatic void finish_cell();
    out_t       c;
    logic [7:0] m;
    vol_kind_e  vk;
    logic [7:0] vv;
    m = mask_mem[chan];
    c = '0;
    c.result_kind     = RES_CELL;
    c.row_index       = row[7:0];
    c.channel_index   = chan;
    c.highest_channel = top_chan;
    if (m[0] || m[4]) begin
      c.change_flags[0] = 1'b1;
      c.note_value      = note_mem[chan];
    end
    if (m[1] || m[5]) begin
      c.change_flags[1]  = 1'b1;
      c.instrument_value = inst_mem[chan];
    end
    if (m[2] || m[6]) begin
      c.change_flags[2] = 1'b1;
      split_volume(vol_mem[chan], vk, vv);
    end else begin
      vk = VK_V;
      vv = VOL_ABSENT;
    end
    c.volume_kind  = vk;
    c.volume_value = vv;
    if (m[3] || m[7]) begin
      c.change_flags[3] = 1'b1;
      c.command_code    = cmd_mem[chan];
      c.command_operand = opnd_mem[chan];
    end
    cells_due.push_back(c);
    phase = ST_CHAN;
  endfunction

  // skip to the next field byte the mask announces, or close the cell
  function automatic void next_field(parse_e from);
    logic [7:0] m;
    m = mask_mem[chan];
    for (int k = int'(from) + 1; k <= int'(ST_CMD); k++) begin
      if (m[k - int'(ST_NOTE)]) begin
        phase = parse_e'(k);
        return;
      end
    end
    finish_cell();
  endfunction

  // row terminator, the pattern ends once the row limit is reached
  function automatic void close_row();
    out_t       e;
    logic [9:0] nxt;
    logic [8:0] lim;
    lim = (rows_limit == '0) ? 9'd1 : rows_limit;
    nxt = {1'b0, row} + 10'd1;
    if (nxt >= {1'b0, lim}) begin
      e = '0;
      e.result_kind     = RES_END;
      e.row_index       = row[7:0];
      e.volume_kind     = VK_V;
      e.highest_channel = top_chan;
      cells_due.push_back(e);
      phase = ST_DONE;
    end else begin
      row = nxt[8:0];
    end
  endfunction

  // one accepted input item
  function automatic void unpack_byte(req_e kind, logic [7:0] b);
    if (kind == REQ_START) begin
      clear_pattern();
      return;
    end
    case (phase)
      ST_CHAN: begin
        if (b == 8'd0) begin
          close_row();
        end else begin
          chan = b[5:0] - 6'd1;
          if (chan > top_chan) top_chan = chan;
          if (b[7]) phase = ST_MASK;
          else next_field(ST_MASK);
        end
      end
      ST_MASK: begin
        mask_mem[chan] = b;
        next_field(ST_MASK);
      end
      ST_NOTE: begin
        note_mem[chan] = b;
        next_field(ST_NOTE);
      end
      ST_INST: begin
        inst_mem[chan] = b;
        next_field(ST_INST);
      end
      ST_VOL: begin
        vol_mem[chan] = b;
        next_field(ST_VOL);
      end
      ST_CMD: begin
        cmd_mem[chan] = b;
        phase = ST_OPND;
      end
      ST_OPND: begin
        opnd_mem[chan] = b;
        finish_cell();
      end
      default: ;
    endcase
  endfunction

  task automatic compare_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      if (mism < 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
      mism++;
    end
  endtask

  // one accepted result item against the oldest prediction
  task automatic check_result();
    out_t want;
    out_t got;
    got.result_kind      = rsp_mon.result_kind;
    got.row_index        = rsp_mon.row_index;
    got.channel_index    = rsp_mon.channel_index;
    got.change_flags     = rsp_mon.change_flags;
    got.note_value       = rsp_mon.note_value;
    got.instrument_value = rsp_mon.instrument_value;
    got.volume_kind      = rsp_mon.volume_kind;
    got.volume_value     = rsp_mon.volume_value;
    got.command_code     = rsp_mon.command_code;
    got.command_operand  = rsp_mon.command_operand;
    got.highest_channel  = rsp_mon.highest_channel;
    if (cells_due.size() == 0) begin
      if (mism < 10)
        $display("%0t: result with nothing expected (kind %0d row %0d ch %0d)",
                 $realtime, got.result_kind, got.row_index, got.channel_index);
      mism++;
      return;
    end
    want = cells_due.pop_front();
    if (want.result_kind == RES_END) n_ends++;
    else n_cells++;
    compare_field("result_kind", want.result_kind, got.result_kind);
    compare_field("row_index", want.row_index, got.row_index);
    compare_field("channel_index", want.channel_index, got.channel_index);
    compare_field("change_flags", want.change_flags, got.change_flags);
    compare_field("note_value", want.note_value, got.note_value);
    compare_field("instrument_value", want.instrument_value, got.instrument_value);
    compare_field("volume_kind", want.volume_kind, got.volume_kind);
    compare_field("volume_value", want.volume_value, got.volume_value);
    compare_field("command_code", want.command_code, got.command_code);
    compare_field("command_operand", want.command_operand, got.command_operand);
    compare_field("highest_channel", want.highest_channel, got.highest_channel);
  endtask

  // watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_limit = 9'(ROWCNT_RESET);
      clear_pattern();
      cells_due.delete();
      mism    = 0;
      n_cells = 0;
      n_ends  = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) rows_limit = cfg_mon.row_count;
      if (req_mon.valid && req_mon.ready) unpack_byte(req_mon.req_type, req_mon.data_byte);
      if (rsp_mon.valid && rsp_mon.ready) check_result();
    end
    mism_o  <= mism;
    pend_o  <= cells_due.size();
    cells_o <= n_cells;
    ends_o  <= n_ends;
  end

endmodule

/* tb/tb.sv */
// testbench top: drives the pattern byte stream, result backpressure and row-count writes
`timescale 1ns / 100ps

module tb;
  import tpu_pkg::*;

  // field bytes at the volume range borders and the byte extremes
  localparam logic [23:0][7:0] EDGE_BYTES = {
    8'd0, 8'd1, 8'd63, 8'd64, 8'd65, 8'd74, 8'd75, 8'd84, 8'd85, 8'd94, 8'd95, 8'd104,
    8'd105, 8'd114, 8'd115, 8'd124, 8'd125, 8'd127, 8'd128, 8'd192, 8'd193, 8'd202,
    8'd203, 8'd255};

  // opening stream, sent from the leftmost byte on
  localparam logic [18:0][7:0] OPENING = {
    8'h81, 8'hFF, 8'hFF, 8'h00, 8'd65, 8'hFF, 8'h00,   // ch0, new full mask, a volume
    8'hC0, 8'h00,                                      // ch63, empty mask
    8'h41, 8'h00, 8'hFF, 8'd202, 8'h00, 8'hFF,         // ch0 again, reused mask, g volume
    8'h00,                                             // end of row 0
    8'h82, 8'hF0,                                      // ch1, new mask of reuse bits only, nothing saved yet
    8'h3F};                                            // ch62, no mask at all

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tpu_in_if  req_if ();
  tpu_out_if rsp_if ();
  tpu_cfg_if cfg_if ();

  int mism;
  int pend;
  int cells_seen;
  int ends_seen;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_len      = 0;
  int items_sent    = 0;

  // what the stream generator assumes about the pattern
  logic [7:0] gen_mask [CHANNELS];
  logic [8:0] gen_limit;
  logic [8:0] gen_row;
  bit         gen_done;

  tracker_pattern_unpacker DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  tpu_cell_checker u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_mon (req_if),
    .rsp_mon (rsp_if),
    .cfg_mon (cfg_if),
    .mism_o  (mism),
    .pend_o  (pend),
    .cells_o (cells_seen),
    .ends_o  (ends_seen)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // result side: random stalls, or a long hold when asked
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // offer one item, with a random gap first, and wait until it is taken
  task automatic push_byte(req_e kind, logic [7:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.data_byte <= b;
    do @(posedge clk_i); while (!req_if.ready);
    if (!(gen_done && kind == REQ_DATA)) items_sent++;
  endtask

  task automatic send_start();
    push_byte(REQ_START, 8'($urandom_range(0, 255)));
    for (int i = 0; i < CHANNELS; i++) gen_mask[i] = '0;
    gen_row  = '0;
    gen_done = 1'b0;
  endtask

  // drop valid and let every prediction drain
  task automatic quiesce();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pend != 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_rows(logic [8:0] n);
    quiesce();
    cfg_if.valid     <= 1'b1;
    cfg_if.row_count <= n;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    gen_limit = n;
  endtask

  function automatic logic [7:0] field_byte();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return EDGE_BYTES[$urandom_range(0, 23)];
  endfunction

  function automatic logic [7:0] pick_mask();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h0F;
      3:       return 8'hF0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // a few channels most of the time so saved values get reused
  function automatic logic [5:0] pick_chan();
    if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 7));
  endfunction

  function automatic logic [8:0] pick_rows();
    if ($urandom_range(0, 9) == 0) return 9'd0;
    return 9'($urandom_range(1, 6));
  endfunction

  // one well-formed channel cell; bit 7 of the channel byte loads a new mask
  task automatic send_cell(logic [5:0] ch);
    logic [7:0] m;
    int         k;
    if ($urandom_range(0, 1)) begin
      k = (ch == 6'd63) ? $urandom_range(1, 2) : $urandom_range(2, 3);
      push_byte(REQ_DATA, 8'(int'(ch) + 1 + 64 * k));
      m = pick_mask();
      push_byte(REQ_DATA, m);
      gen_mask[ch] = m;
    end else begin
      k = (ch == 6'd63) ? 0 : $urandom_range(0, 1);
      push_byte(REQ_DATA, 8'(int'(ch) + 1 + 64 * k));
      m = gen_mask[ch];
    end
    if (m[0]) push_byte(REQ_DATA, field_byte());
    if (m[1]) push_byte(REQ_DATA, field_byte());
    if (m[2]) push_byte(REQ_DATA, field_byte());
    if (m[3]) begin
      push_byte(REQ_DATA, field_byte());
      push_byte(REQ_DATA, field_byte());
    end
  endtask

  task automatic send_row(int max_cells);
    int n;
    n = $urandom_range(0, max_cells);
    repeat (n) send_cell(pick_chan());
    push_byte(REQ_DATA, 8'd0);
    if (int'(gen_row) + 1 >= ((gen_limit == '0) ? 1 : int'(gen_limit))) gen_done = 1'b1;
    else gen_row++;
  endtask

  // short pattern, sometimes cut off, sometimes with the limit lowered midway
  task automatic short_pattern();
    int cut;
    set_rows(pick_rows());
    send_start();
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 1000;
    while (!gen_done && cut > 0) begin
      if (gen_row == 9'd3 && gen_limit > 9'd4 && $urandom_range(0, 3) == 0)
        set_rows(9'($urandom_range(0, 3)));
      send_row(3);
      cut--;
    end
    if (gen_done && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) push_byte(REQ_DATA, field_byte());
  endtask

  // many rows, few cells
  task automatic long_pattern(logic [8:0] lim, int rows);
    set_rows(lim);
    send_start();
    repeat (rows) if (!gen_done) send_row(($urandom_range(0, 7) == 0) ? 1 : 0);
  endtask

  // raw bytes that break cells apart, then a fresh pattern
  task automatic noise_burst();
    repeat ($urandom_range(3, 12))
      push_byte(($urandom_range(0, 15) == 0) ? REQ_START : REQ_DATA,
                8'($urandom_range(0, 255)));
    send_start();
  endtask

  task automatic random_phase(int budget);
    int stop;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      if ($urandom_range(0, 7) == 0) noise_burst();
      else short_pattern();
    end
  endtask

  // hold results back long enough that the block stops taking bytes
  task automatic squeeze();
    set_rows(9'd256);
    send_start();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    hold_len = 200;
    @(posedge clk_i);
    repeat (12) send_cell(pick_chan());
  endtask

  initial begin
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_DATA;
    req_if.data_byte = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.row_count = '0;
    gen_limit        = 9'(ROWCNT_RESET);
    gen_row          = '0;
    gen_done         = 1'b0;
    for (int i = 0; i < CHANNELS; i++) gen_mask[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // opening cases under the reset row limit
    push_byte(REQ_START, 8'hFF);
    for (int i = 18; i >= 0; i--) push_byte(REQ_DATA, OPENING[i]);
    // limit of zero acts as one, bytes after the end are dropped
    set_rows(9'd0);
    push_byte(REQ_DATA, 8'h00);
    push_byte(REQ_DATA, 8'h81);
    push_byte(REQ_START, 8'h00);
    push_byte(REQ_DATA, 8'h00);

    // idle mixes: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 83; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      random_phase(250);
      if (ph == 0) squeeze();
      if (ph == 1) long_pattern(9'd256, 256);
      if (ph == 3) long_pattern(9'd511, 270);
    end

    req_if.valid <= 1'b0;
    for (int i = 0; i < 200000 && pend != 0; i++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("summary: %0d input items, %0d cells and %0d pattern ends checked",
             items_sent, cells_seen, ends_seen);
    $display("summary: row limits 0 to 511, four idle mixes and one long result hold");
    if (pend != 0) $display("%0d expected results never arrived", pend);
    if (mism == 0 && pend == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
src/tpu_pkg.sv
src/tpu_if.sv
src/tpu_ram.sv
src/tracker_pattern_unpacker.sv
tb/tpu_cell_checker.sv
tb/tb.sv
